[rtl/core/tcw_pkg.sv]
// tcw_pkg: shared types and constants of the text console character writer
// field widths, character codes, register indexes, controller/datapath bundles
// no dependencies
package tcw_pkg;

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 16;
  localparam int IN_ROW_W    = 6;
  localparam int IN_COL_W    = 7;
  localparam int CUR_ROW_W   = 6;
  localparam int CUR_COL_W   = 7;
  localparam int COLS_REG_W  = 8;
  localparam int ROWS_REG_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 40;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam int                TAB_STOP   = 4;
  localparam int                TAB_STOP_W = $clog2(TAB_STOP);

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS       = 2'd0,
    CFG_ROWS       = 2'd1,
    CFG_TEXT_ATTR  = 2'd2,
    CFG_BLANK_ATTR = 2'd3
  } cfg_idx_e;

  localparam logic [COLS_REG_W-1:0] COLS_RST       = 8'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RST       = 7'd25;
  localparam logic [ATTR_W-1:0]     TEXT_ATTR_RST  = 16'd7;
  localparam logic [ATTR_W-1:0]     BLANK_ATTR_RST = 16'd0;
  localparam logic [ATTR_W-1:0]     CLEAR_ATTR     = 16'd0;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_ACCEPT,
    DP_RDATA,
    DP_FILL,
    DP_ADVANCE,
    DP_COPY,
    DP_DRAIN,
    DP_BLANK
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_read;
    logic clear_last;
    logic fill_skip;
    logic fill_last;
    logic need_scroll;
    logic multi_row;
    logic copy_last;
    logic blank_last;
  } dp_status_t;

endpackage

[rtl/core/tcw_ram.sv]
// tcw_ram: generic single write port, single read port RAM with registered read
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tcw_datapath.sv]
// tcw_datapath: screen store, cursor, configuration registers and result registers
// depends on tcw_pkg and tcw_ram
module tcw_datapath #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcw_pkg::dp_cmd_t                    cmd_i,
  output tcw_pkg::dp_status_t                 status_o,
  input  logic                                in_opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]          in_char_i,
  input  logic [tcw_pkg::IN_ROW_W-1:0]        in_row_i,
  input  logic [tcw_pkg::IN_COL_W-1:0]        in_col_i,
  input  logic                                cfg_valid_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [tcw_pkg::CHAR_W-1:0]          out_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]          out_attr_o,
  output logic [tcw_pkg::CUR_ROW_W-1:0]       out_row_o,
  output logic [tcw_pkg::CUR_COL_W-1:0]       out_col_o,
  output logic                                out_scrolled_o
);

  localparam int CW     = $clog2(MAX_COLS);
  localparam int CCW    = $clog2(MAX_COLS + 1);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int AW     = RW + CW;
  localparam int DEPTH  = MAX_ROWS * (2 ** CW);
  localparam int CHW    = tcw_pkg::CHAR_W;
  localparam int ATW    = tcw_pkg::ATTR_W;
  localparam int WORD_W = CHW + ATW;
  localparam int CRW    = tcw_pkg::CUR_ROW_W;
  localparam int CCLW   = tcw_pkg::CUR_COL_W;
  localparam int TSW    = tcw_pkg::TAB_STOP_W;

  function automatic logic [CCW-1:0] eff_cols_f(input logic [tcw_pkg::COLS_REG_W-1:0] v);
    logic [CCW-1:0] r;
    if (v == '0) begin
      r = CCW'(1);
    end else if (int'(v) > MAX_COLS) begin
      r = CCW'(MAX_COLS);
    end else begin
      r = CCW'(v);
    end
    return r;
  endfunction

  function automatic logic [RCW-1:0] eff_rows_f(input logic [tcw_pkg::ROWS_REG_W-1:0] v);
    logic [RCW-1:0] r;
    if (v == '0) begin
      r = RCW'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = RCW'(MAX_ROWS);
    end else begin
      r = RCW'(v);
    end
    return r;
  endfunction

  logic [tcw_pkg::COLS_REG_W-1:0] cols_q, cols_d;
  logic [tcw_pkg::ROWS_REG_W-1:0] rows_q, rows_d;
  logic [ATW-1:0]                 text_attr_q, text_attr_d;
  logic [ATW-1:0]                 blank_attr_q, blank_attr_d;
  logic [RW-1:0]                  row_q, row_d;
  logic [CCW-1:0]                 col_q, col_d;
  logic [AW-1:0]                  clr_cnt_q, clr_cnt_d;
  logic [RW-1:0]                  scan_row_q, scan_row_d;
  logic [CW-1:0]                  scan_col_q, scan_col_d;
  logic                           pend_valid_q, pend_valid_d;

  logic [CHW-1:0]                 ch_q, ch_d;
  logic                           rd_ok_q, rd_ok_d;
  logic [AW-1:0]                  pend_addr_q, pend_addr_d;
  logic [CHW-1:0]                 res_char_q, res_char_d;
  logic [ATW-1:0]                 res_attr_q, res_attr_d;
  logic                           scrolled_q, scrolled_d;
  logic [CHW-1:0]                 out_char_q, out_char_d;
  logic [ATW-1:0]                 out_attr_q, out_attr_d;
  logic [CRW-1:0]                 out_row_q, out_row_d;
  logic [CCLW-1:0]                out_col_q, out_col_d;
  logic                           out_scr_q, out_scr_d;

  logic [CCW-1:0]                 eff_cols, new_cols, col_inc;
  logic [RCW-1:0]                 eff_rows, new_rows;
  logic [RW-1:0]                  last_row, scan_row_inc;
  logic                           is_ctrl, wrap;

  logic                           ram_we, ram_re;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [WORD_W-1:0]              ram_wdata, ram_rdata;

  assign eff_cols     = eff_cols_f(cols_q);
  assign eff_rows     = eff_rows_f(rows_q);
  assign new_cols     = eff_cols_f(cfg_data_i[tcw_pkg::COLS_REG_W-1:0]);
  assign new_rows     = eff_rows_f(cfg_data_i[tcw_pkg::ROWS_REG_W-1:0]);
  assign last_row     = RW'(eff_rows - RCW'(1));
  assign col_inc      = col_q + CCW'(1);
  assign scan_row_inc = scan_row_q + RW'(1);
  assign is_ctrl      = (ch_q == tcw_pkg::CH_NEWLINE) || (ch_q == tcw_pkg::CH_TAB);
  assign wrap         = col_q >= eff_cols;

  always_comb begin
    status_o.in_is_read  = in_opcode_i == tcw_pkg::OP_READ;
    status_o.clear_last  = clr_cnt_q == AW'(DEPTH - 1);
    status_o.fill_skip   = is_ctrl && (col_q == '0);
    status_o.fill_last   = !is_ctrl || (col_inc >= eff_cols) ||
                           ((ch_q == tcw_pkg::CH_TAB) && (col_inc[TSW-1:0] == '0));
    status_o.need_scroll = wrap && (row_q == last_row);
    status_o.multi_row   = eff_rows > RCW'(1);
    status_o.copy_last   = (scan_row_q == RW'(eff_rows - RCW'(2))) &&
                           (scan_col_q == CW'(MAX_COLS - 1));
    status_o.blank_last  = scan_col_q == CW'(MAX_COLS - 1);
  end

  // store port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (cmd_i.op)
      tcw_pkg::DP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = {tcw_pkg::CH_SPACE, tcw_pkg::CLEAR_ATTR};
      end
      tcw_pkg::DP_ACCEPT: begin
        ram_re    = in_opcode_i == tcw_pkg::OP_READ;
        ram_raddr = {RW'(in_row_i), CW'(in_col_i)};
      end
      tcw_pkg::DP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = {row_q, col_q[CW-1:0]};
        ram_wdata = is_ctrl ? {tcw_pkg::CH_SPACE, blank_attr_q} : {ch_q, text_attr_q};
      end
      tcw_pkg::DP_COPY: begin
        ram_re    = 1'b1;
        ram_raddr = {scan_row_inc, scan_col_q};
        ram_we    = pend_valid_q;
        ram_waddr = pend_addr_q;
        ram_wdata = ram_rdata;
      end
      tcw_pkg::DP_DRAIN: begin
        ram_we    = pend_valid_q;
        ram_waddr = pend_addr_q;
        ram_wdata = ram_rdata;
      end
      tcw_pkg::DP_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = {last_row, scan_col_q};
        ram_wdata = {tcw_pkg::CH_SPACE, blank_attr_q};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cols_d       = cols_q;
    rows_d       = rows_q;
    text_attr_d  = text_attr_q;
    blank_attr_d = blank_attr_q;
    row_d        = row_q;
    col_d        = col_q;
    clr_cnt_d    = clr_cnt_q;
    scan_row_d   = scan_row_q;
    scan_col_d   = scan_col_q;
    pend_valid_d = pend_valid_q;
    ch_d         = ch_q;
    rd_ok_d      = rd_ok_q;
    pend_addr_d  = pend_addr_q;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    scrolled_d   = scrolled_q;
    out_char_d   = out_char_q;
    out_attr_d   = out_attr_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_scr_d    = out_scr_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        tcw_pkg::CFG_COLS: begin
          cols_d = cfg_data_i[tcw_pkg::COLS_REG_W-1:0];
          if (col_q >= new_cols) begin
            col_d = new_cols - CCW'(1);
          end
        end
        tcw_pkg::CFG_ROWS: begin
          rows_d = cfg_data_i[tcw_pkg::ROWS_REG_W-1:0];
          if (RCW'(row_q) >= new_rows) begin
            row_d = RW'(new_rows - RCW'(1));
          end
        end
        tcw_pkg::CFG_TEXT_ATTR:  text_attr_d  = cfg_data_i;
        tcw_pkg::CFG_BLANK_ATTR: blank_attr_d = cfg_data_i;
        default: begin
        end
      endcase
    end

    case (cmd_i.op)
      tcw_pkg::DP_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      tcw_pkg::DP_ACCEPT: begin
        ch_d       = in_char_i;
        rd_ok_d    = (int'(in_row_i) < MAX_ROWS) && (int'(in_col_i) < MAX_COLS);
        res_char_d = '0;
        res_attr_d = '0;
        scrolled_d = 1'b0;
      end
      tcw_pkg::DP_RDATA: begin
        if (rd_ok_q) begin
          {res_char_d, res_attr_d} = ram_rdata;
        end
      end
      tcw_pkg::DP_FILL: begin
        col_d = col_inc;
      end
      tcw_pkg::DP_ADVANCE: begin
        scan_row_d   = '0;
        scan_col_d   = '0;
        pend_valid_d = 1'b0;
        if (wrap) begin
          col_d = '0;
          if (row_q == last_row) begin
            scrolled_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end
      end
      tcw_pkg::DP_COPY: begin
        pend_valid_d = 1'b1;
        pend_addr_d  = {scan_row_q, scan_col_q};
        if (scan_col_q == CW'(MAX_COLS - 1)) begin
          scan_col_d = '0;
          scan_row_d = scan_row_inc;
        end else begin
          scan_col_d = scan_col_q + CW'(1);
        end
      end
      tcw_pkg::DP_DRAIN: begin
        pend_valid_d = 1'b0;
      end
      tcw_pkg::DP_BLANK: begin
        scan_col_d = scan_col_q + CW'(1);
      end
      default: begin
      end
    endcase

    if (cmd_i.load_out) begin
      out_char_d = res_char_q;
      out_attr_d = res_attr_q;
      out_row_d  = CRW'(row_q);
      out_col_d  = CCLW'(col_q);
      out_scr_d  = scrolled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q       <= tcw_pkg::COLS_RST;
      rows_q       <= tcw_pkg::ROWS_RST;
      text_attr_q  <= tcw_pkg::TEXT_ATTR_RST;
      blank_attr_q <= tcw_pkg::BLANK_ATTR_RST;
      row_q        <= '0;
      col_q        <= '0;
      clr_cnt_q    <= '0;
      scan_row_q   <= '0;
      scan_col_q   <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      cols_q       <= cols_d;
      rows_q       <= rows_d;
      text_attr_q  <= text_attr_d;
      blank_attr_q <= blank_attr_d;
      row_q        <= row_d;
      col_q        <= col_d;
      clr_cnt_q    <= clr_cnt_d;
      scan_row_q   <= scan_row_d;
      scan_col_q   <= scan_col_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q        <= ch_d;
    rd_ok_q     <= rd_ok_d;
    pend_addr_q <= pend_addr_d;
    res_char_q  <= res_char_d;
    res_attr_q  <= res_attr_d;
    scrolled_q  <= scrolled_d;
    out_char_q  <= out_char_d;
    out_attr_q  <= out_attr_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_scr_q   <= out_scr_d;
  end

  tcw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_char_o     = out_char_q;
  assign out_attr_o     = out_attr_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_scrolled_o = out_scr_q;

  // scroll copy never reads the row it is writing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr[AW-1:CW] != ram_raddr[AW-1:CW]))
    else $error("scroll copy read and write hit the same row");

endmodule

[rtl/core/tcw_ctrl.sv]
// tcw_ctrl: sequencer of the text console writer
// drives datapath commands and the stream handshakes; depends on tcw_pkg
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDATA,
    ST_FILL,
    ST_ADVANCE,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !m_tready_i;
    cmd_o.op       = tcw_pkg::DP_NOP;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = tcw_pkg::DP_CLEAR;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = tcw_pkg::DP_ACCEPT;
          state_d  = status_i.in_is_read ? ST_RDATA : ST_FILL;
        end
      end
      ST_RDATA: begin
        cmd_o.op = tcw_pkg::DP_RDATA;
        state_d  = ST_FINISH;
      end
      ST_FILL: begin
        if (!status_i.fill_skip) begin
          cmd_o.op = tcw_pkg::DP_FILL;
        end
        if (status_i.fill_skip || status_i.fill_last) begin
          state_d = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd_o.op = tcw_pkg::DP_ADVANCE;
        if (status_i.need_scroll) begin
          state_d = status_i.multi_row ? ST_COPY : ST_BLANK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_COPY: begin
        cmd_o.op = tcw_pkg::DP_COPY;
        if (status_i.copy_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.op = tcw_pkg::DP_DRAIN;
        state_d  = ST_BLANK;
      end
      ST_BLANK: begin
        cmd_o.op = tcw_pkg::DP_BLANK;
        if (status_i.blank_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = out_valid_q;

  // one item in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("second transaction accepted while an item is in flight");

  // a result appears only when the finish step hands it over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the finish step");

  // a waiting result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && !m_tready_i) |=>
      (state_q == ST_FINISH && m_tvalid_o))
    else $error("pending result overwritten");

endmodule

[rtl/core/text_console_char_writer.sv]
// text_console_char_writer: top level of the text console character writer
// joins tcw_ctrl and tcw_datapath; depends on tcw_pkg
//
// channel  direction  handshake                     payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata: char, read row, read col; tuser: opcode
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata: cell, cursor, scrolled flag
// cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// read steps: accept, store read, finish; printed character: accept, fill, advance, finish
// newline or tab: accept, fill of the blanked cells, advance, finish; at column 0 the fill step writes no cell
// scroll: over two or more rows the rows in use are copied up (copy, drain), then MAX_COLS cells are blanked
// after reset a clearing pass over all MAX_ROWS*2**clog2(MAX_COLS) store words holds s_axis_tready low
// one item at a time; a finished result waits in the output register while the next is taken
module text_console_char_writer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // character [7:0], read_row [13:8], read_col [20:14], zero [23:21]
  input  logic [tcw_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // opcode [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cell_char [7:0], cell_attr [23:8], cursor_row [29:24], cursor_col [36:30],
  // scrolled [37], zero [39:38]
  output logic [tcw_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  tcw_pkg::dp_cmd_t    cmd;
  tcw_pkg::dp_status_t status;

  logic [tcw_pkg::CHAR_W-1:0]    out_char;
  logic [tcw_pkg::ATTR_W-1:0]    out_attr;
  logic [tcw_pkg::CUR_ROW_W-1:0] out_row;
  logic [tcw_pkg::CUR_COL_W-1:0] out_col;
  logic                          out_scrolled;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tcw_datapath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_opcode_i   (s_axis_tuser),
    .in_char_i     (s_axis_tdata[7:0]),
    .in_row_i      (s_axis_tdata[13:8]),
    .in_col_i      (s_axis_tdata[20:14]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_char_o    (out_char),
    .out_attr_o    (out_attr),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_scrolled_o(out_scrolled)
  );

  assign m_axis_tdata = {2'b00, out_scrolled, out_col, out_row, out_attr, out_char};

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench of the text console character writer
// keeps its own model of the screen store and cursor in a scoreboard class
// depends on tcw_pkg and the text_console_char_writer rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_W     = tcw_pkg::CHAR_W;
  localparam int ATTR_W     = tcw_pkg::ATTR_W;
  localparam int CUR_ROW_W  = tcw_pkg::CUR_ROW_W;
  localparam int CUR_COL_W  = tcw_pkg::CUR_COL_W;
  localparam int COLS_REG_W = tcw_pkg::COLS_REG_W;
  localparam int ROWS_REG_W = tcw_pkg::ROWS_REG_W;
  localparam int CFG_IDX_W  = tcw_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tcw_pkg::CFG_DATA_W;
  localparam int IN_ROW_W   = tcw_pkg::IN_ROW_W;
  localparam int IN_COL_W   = tcw_pkg::IN_COL_W;
  localparam int S_TDATA_W  = tcw_pkg::S_TDATA_W;
  localparam int M_TDATA_W  = tcw_pkg::M_TDATA_W;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int unsigned QUIET_LIMIT = 50000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int NUM_PHASES = 13;
  localparam int unsigned PHASE_COLS [NUM_PHASES] =
    '{8, 5, 0, 128, 255, 1, 2, 13, 80, 128, 3, 4, 7};
  localparam int unsigned PHASE_ROWS [NUM_PHASES] =
    '{2, 3, 0, 4, 2, 64, 127, 6, 25, 64, 1, 8, 5};
  localparam int unsigned PHASE_ITEMS [NUM_PHASES] =
    '{150, 150, 60, 150, 100, 80, 24, 150, 120, 60, 100, 150, 150};
  localparam bit PHASE_PLAIN [NUM_PHASES] =
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 scrolled;
  } cell_result_t;

  class console_scoreboard;
    logic [CHAR_W-1:0] char_mem [MAX_ROWS*MAX_COLS];
    logic [ATTR_W-1:0] attr_mem [MAX_ROWS*MAX_COLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [COLS_REG_W-1:0] cols_reg;
    logic [ROWS_REG_W-1:0] rows_reg;
    logic [ATTR_W-1:0]     text_attr;
    logic [ATTR_W-1:0]     blank_attr;
    cell_result_t      expected_cells [$];
    int unsigned       fail_count;
    int unsigned       result_count;

    function new();
      for (int a = 0; a < MAX_ROWS*MAX_COLS; a++) begin
        char_mem[a] = tcw_pkg::CH_SPACE;
        attr_mem[a] = tcw_pkg::CLEAR_ATTR;
      end
      cur_row      = 0;
      cur_col      = 0;
      cols_reg     = tcw_pkg::COLS_RST;
      rows_reg     = tcw_pkg::ROWS_RST;
      text_attr    = tcw_pkg::TEXT_ATTR_RST;
      blank_attr   = tcw_pkg::BLANK_ATTR_RST;
      fail_count   = 0;
      result_count = 0;
    endfunction

    function int unsigned eff_cols();
      if (cols_reg == 0) return 1;
      if (32'(cols_reg) > MAX_COLS) return MAX_COLS;
      return 32'(cols_reg);
    endfunction

    function int unsigned eff_rows();
      if (rows_reg == 0) return 1;
      if (32'(rows_reg) > MAX_ROWS) return MAX_ROWS;
      return 32'(rows_reg);
    endfunction

    function void clamp_cursor();
      if (cur_col >= eff_cols()) cur_col = eff_cols() - 1;
      if (cur_row >= eff_rows()) cur_row = eff_rows() - 1;
    endfunction

    function void write_cell(int unsigned r, int unsigned c, logic [CHAR_W-1:0] ch,
                             logic [ATTR_W-1:0] attr);
      char_mem[r*MAX_COLS + c] = ch;
      attr_mem[r*MAX_COLS + c] = attr;
    endfunction

    // rows in use move up over the full store width, bottom row in use blanked
    function void scroll_up(int unsigned rows);
      for (int unsigned a = 0; a < (rows - 1) * MAX_COLS; a++) begin
        char_mem[a] = char_mem[a + MAX_COLS];
        attr_mem[a] = attr_mem[a + MAX_COLS];
      end
      for (int unsigned c = 0; c < MAX_COLS; c++)
        write_cell(rows - 1, c, tcw_pkg::CH_SPACE, blank_attr);
    endfunction

    function void apply_reg(tcw_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        tcw_pkg::CFG_COLS: begin
          cols_reg = value[COLS_REG_W-1:0];
          clamp_cursor();
        end
        tcw_pkg::CFG_ROWS: begin
          rows_reg = value[ROWS_REG_W-1:0];
          clamp_cursor();
        end
        tcw_pkg::CFG_TEXT_ATTR:  text_attr = value;
        tcw_pkg::CFG_BLANK_ATTR: blank_attr = value;
        default: ;
      endcase
    endfunction

    function void note_item(logic op, logic [CHAR_W-1:0] ch, logic [IN_ROW_W-1:0] rr,
                            logic [IN_COL_W-1:0] rc);
      cell_result_t want;
      int unsigned  cols;
      int unsigned  rows;
      int unsigned  r;
      int unsigned  c;
      want = '0;
      if (op == tcw_pkg::OP_READ) begin
        want.cell_char = char_mem[32'(rr)*MAX_COLS + 32'(rc)];
        want.cell_attr = attr_mem[32'(rr)*MAX_COLS + 32'(rc)];
      end else begin
        cols = eff_cols();
        rows = eff_rows();
        clamp_cursor();
        r = cur_row;
        c = cur_col;
        if (ch == tcw_pkg::CH_NEWLINE) begin
          if (c != 0) begin
            while (c < cols) begin
              write_cell(r, c, tcw_pkg::CH_SPACE, blank_attr);
              c++;
            end
          end
        end else if (ch == tcw_pkg::CH_TAB) begin
          if (c != 0) begin
            do begin
              write_cell(r, c, tcw_pkg::CH_SPACE, blank_attr);
              c++;
            end while (c < cols && (c % tcw_pkg::TAB_STOP) != 0);
          end
        end else begin
          write_cell(r, c, ch, text_attr);
          c++;
        end
        if (c >= cols) begin
          c = 0;
          r++;
        end
        if (r >= rows) begin
          scroll_up(rows);
          r = rows - 1;
          want.scrolled = 1'b1;
        end
        cur_row = r;
        cur_col = c;
      end
      want.cursor_row = CUR_ROW_W'(cur_row);
      want.cursor_col = CUR_COL_W'(cur_col);
      expected_cells.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      fail_count++;
    endtask

    task check_cell(logic [M_TDATA_W-1:0] tdata);
      cell_result_t got;
      cell_result_t want;
      got.cell_char  = tdata[7:0];
      got.cell_attr  = tdata[23:8];
      got.cursor_row = tdata[29:24];
      got.cursor_col = tdata[36:30];
      got.scrolled   = tdata[37];
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction 0x%0h", tdata));
        return;
      end
      want = expected_cells.pop_front();
      if (got.cell_char != want.cell_char)
        report_mismatch($sformatf("result %0d cell_char 0x%0h, expected 0x%0h",
                                  result_count, got.cell_char, want.cell_char));
      if (got.cell_attr != want.cell_attr)
        report_mismatch($sformatf("result %0d cell_attr 0x%0h, expected 0x%0h",
                                  result_count, got.cell_attr, want.cell_attr));
      if (got.cursor_row != want.cursor_row)
        report_mismatch($sformatf("result %0d cursor_row %0d, expected %0d",
                                  result_count, got.cursor_row, want.cursor_row));
      if (got.cursor_col != want.cursor_col)
        report_mismatch($sformatf("result %0d cursor_col %0d, expected %0d",
                                  result_count, got.cursor_col, want.cursor_col));
      if (got.scrolled != want.scrolled)
        report_mismatch($sformatf("result %0d scrolled %0b, expected %0b",
                                  result_count, got.scrolled, want.scrolled));
      result_count++;
    endtask

    function int unsigned pending_count();
      return expected_cells.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = tcw_pkg::OP_PUT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = tcw_pkg::CFG_COLS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  console_scoreboard sb = new();
  int unsigned       burst_left = 0;
  int unsigned       rx_tick = 0;
  int unsigned       rx_mode = 0;

  text_console_char_writer #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [IN_ROW_W-1:0] rr, input logic [IN_COL_W-1:0] rc);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, rc, rr, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, ch, rr, rc);
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_item(tcw_pkg::OP_PUT, ch, IN_ROW_W'($urandom_range(0, 63)),
              IN_COL_W'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input logic [IN_ROW_W-1:0] rr, input logic [IN_COL_W-1:0] rc);
    send_item(tcw_pkg::OP_READ, CHAR_W'($urandom_range(0, 255)), rr, rc);
  endtask

  task automatic send_random_item(input bit plain);
    logic                op;
    logic [CHAR_W-1:0]   ch;
    logic [IN_ROW_W-1:0] rr;
    logic [IN_COL_W-1:0] rc;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    op = (pick < (plain ? 10 : 25)) ? tcw_pkg::OP_READ : tcw_pkg::OP_PUT;
    ch = CHAR_W'($urandom_range(0, 255));
    rr = IN_ROW_W'($urandom_range(0, 63));
    rc = IN_COL_W'($urandom_range(0, 127));
    if (op == tcw_pkg::OP_PUT) begin
      if (plain) begin
        if (ch == tcw_pkg::CH_NEWLINE || ch == tcw_pkg::CH_TAB) ch = 8'h2a;
      end else if (pick < 45) begin
        ch = tcw_pkg::CH_NEWLINE;
      end else if (pick < 60) begin
        ch = tcw_pkg::CH_TAB;
      end
    end else if ($urandom_range(0, 9) < 6) begin
      rr = IN_ROW_W'($urandom_range(0, sb.eff_rows() - 1));
      rc = IN_COL_W'($urandom_range(0, sb.eff_cols() - 1));
    end
    send_item(op, ch, rr, rc);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(input tcw_pkg::cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_reg(idx, value);
  endtask

  task automatic program_regs(input logic [COLS_REG_W-1:0] cols,
                              input logic [ROWS_REG_W-1:0] rows,
                              input logic [ATTR_W-1:0] tattr, input logic [ATTR_W-1:0] battr);
    program_reg(tcw_pkg::CFG_COLS, CFG_DATA_W'(cols));
    program_reg(tcw_pkg::CFG_ROWS, CFG_DATA_W'(rows));
    program_reg(tcw_pkg::CFG_TEXT_ATTR, tattr);
    program_reg(tcw_pkg::CFG_BLANK_ATTR, battr);
    cfg_valid_i <= 1'b0;
  endtask

  // output side: checks each accepted result; the stall pattern is drawn at random from four modes
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_cell(m_axis_tdata);
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_tick % 32) >= 20;
    endcase
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [ATTR_W-1:0] tattr;
    logic [ATTR_W-1:0] battr;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 80 columns, 25 rows
    send_read(6'd0, 7'd0);
    send_read(6'd63, 7'd127);
    // newline and tab at column 0 leave the cursor alone
    send_put(tcw_pkg::CH_NEWLINE);
    send_put(tcw_pkg::CH_TAB);
    send_put(8'h41);
    send_put(8'h00);
    send_put(8'hff);
    send_put(tcw_pkg::CH_TAB);
    send_put(tcw_pkg::CH_TAB);
    send_put(tcw_pkg::CH_NEWLINE);
    send_read(6'd0, 7'd0);
    send_read(6'd0, 7'd2);
    settle();

    // single row of six columns: wrapping scrolls the only row
    program_regs(8'd6, 7'd1, 16'hffff, 16'ha5a5);
    repeat (5) send_put(8'h7e);
    send_put(tcw_pkg::CH_TAB);
    send_read(6'd0, 7'd0);
    send_read(6'd1, 7'd0);
    repeat (6) send_put(8'h5a);
    send_put(8'h31);
    send_put(tcw_pkg::CH_NEWLINE);
    send_read(6'd0, 7'd5);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      tattr = (p == 0) ? 16'h0000 : (p == 1) ? 16'hffff : ATTR_W'($urandom_range(0, 65535));
      battr = (p == 0) ? 16'hffff : (p == 1) ? 16'h0000 : ATTR_W'($urandom_range(0, 65535));
      program_regs(COLS_REG_W'(PHASE_COLS[p]), ROWS_REG_W'(PHASE_ROWS[p]), tattr, battr);
      for (int n = 0; n < int'(PHASE_ITEMS[p]); n++) send_random_item(PHASE_PLAIN[p]);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_count() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending_count()));
    if (sb.fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
